@@ src/pcs_pkg.sv @@
// Shared types and constants for the prime count stream block.
// No dependencies; used by prime_count_stream and its port checker.
package pcs_pkg;

  // Running prime count as carried on the result stream
  localparam int COUNT_W = 8;
  typedef logic [COUNT_W-1:0] count_t;

  // Result tdata: is_prime, prime_count, padded to whole bytes
  localparam int M_TDATA_W = ((1 + COUNT_W + 7) / 8) * 8;

endpackage

@@ src/prime_count_stream.sv @@
// Prime count stream: trial-division primality test with a running count per array.
// Depends on pcs_pkg for the count type and result tdata width.
//
// Each request carries one signed value (low VALUE_WIDTH bits of s_axis_tdata) and an
// end-of-array mark on s_axis_tlast. One result comes back per request: its prime flag,
// the number of primes so far in the current array (saturating at MAX_ITEMS, or at 255 if
// MAX_ITEMS is larger) and the end mark on m_axis_tlast. After a last request the count
// restarts at zero. Negative values, zero, one, two, three and even values are settled at
// once. Their result register is loaded from the finish state that follows acceptance,
// and the sequencer then returns to idle for the next request. Other values go through a
// bit-serial restoring divider that takes one quotient bit per cycle, trying each odd
// divisor 3, 5, 7, ... in turn, up to about sqrt(value) / 2 divisors in all. Each divisor
// runs the division steps and then a check of quotient and remainder. Requests are taken
// one at a time. A finished result waits in the output register while the next request
// is accepted and worked on. If that register is still held when the next result is
// ready, the sequencer waits in its final state and no new request is taken.
module prime_count_stream #(
  parameter int MAX_ITEMS   = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // value [VALUE_WIDTH-1:0], zero padding above
  input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,
  input  logic                                       s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // is_prime [0], prime_count [8:1], zero padding above
  output logic [pcs_pkg::M_TDATA_W-1:0]              m_axis_tdata,
  output logic                                       m_axis_tlast
);
  import pcs_pkg::*;

  localparam int W        = VALUE_WIDTH;
  localparam int CW       = $clog2(VALUE_WIDTH);
  localparam int CEIL_INT = (MAX_ITEMS < 255) ? MAX_ITEMS : 255;
  localparam count_t COUNT_CEIL = count_t'(CEIL_INT);
  localparam int PAD_W    = M_TDATA_W - 1 - COUNT_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state;
  logic [W-1:0]  value;      // value under test
  logic [W-1:0]  dividend;   // shifted out MSB first into the divider
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  divisor;
  logic [CW-1:0] bit_cnt;
  logic          last;
  logic          prime;
  count_t        count;
  logic          out_prime;
  count_t        out_count;
  logic          out_last;
  logic          out_valid;

  logic [W-1:0]  value_in;
  logic [W:0]    trial;
  logic          trial_fits;
  count_t        count_next;
  logic          out_free;

  assign value_in   = s_axis_tdata[W-1:0];
  assign trial      = {rem, dividend[W-1]};
  assign trial_fits = trial >= {1'b0, divisor};
  assign count_next = (prime && (count < COUNT_CEIL)) ? count + count_t'(1) : count;
  assign out_free   = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_count, out_prime};
  assign m_axis_tlast  = out_last;

  // Sequence one request: screen, divide per trial divisor, then report
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a finished result, else drop the one that has been taken
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            value    <= value_in;
            last     <= s_axis_tlast;
            dividend <= value_in;
            rem      <= '0;
            divisor  <= W'(3);
            bit_cnt  <= CW'(W - 1);
            // Negative, below two, two or three, even: decided at once
            priority if (value_in[W-1]) begin
              prime <= 1'b0;
              state <= ST_FINISH;
            end else if ((value_in >> 1) == '0) begin
              prime <= 1'b0;
              state <= ST_FINISH;
            end else if ((value_in >> 2) == '0) begin
              prime <= 1'b1;
              state <= ST_FINISH;
            end else if (!value_in[0]) begin
              prime <= 1'b0;
              state <= ST_FINISH;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // One restoring division step per cycle
          if (trial_fits) begin
            rem <= W'(trial - {1'b0, divisor});
          end else begin
            rem <= trial[W-1:0];
          end
          quo      <= {quo[W-2:0], trial_fits};
          dividend <= dividend << 1;
          if (bit_cnt == '0) begin
            state <= ST_CHECK;
          end else begin
            bit_cnt <= bit_cnt - CW'(1);
          end
        end
        ST_CHECK: begin
          // Divisor beyond the square root: prime; exact division: composite
          priority if (quo < divisor) begin
            prime <= 1'b1;
            state <= ST_FINISH;
          end else if (rem == '0) begin
            prime <= 1'b0;
            state <= ST_FINISH;
          end else begin
            divisor  <= divisor + W'(2);
            dividend <= value;
            rem      <= '0;
            bit_cnt  <= CW'(W - 1);
            state    <= ST_DIV;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free, then report and count
          if (out_free) begin
            out_prime <= prime;
            out_count <= count_next;
            out_last  <= last;
            count     <= last ? '0 : count_next;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/pcs_check.sv @@
// Port-level checks for prime_count_stream, attached by the bind below.
// Depends on pcs_pkg for the count type and result tdata width.
module pcs_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [pcs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input logic                              m_axis_tlast
);
  import pcs_pkg::*;

  logic   first;       // next result opens an array
  count_t prev_count;
  logic   in_acc;
  logic   out_acc;
  count_t res_count;
  logic   res_prime;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign res_count = m_axis_tdata[COUNT_W:1];
  assign res_prime = m_axis_tdata[0];

  // Track array boundaries and the last reported count
  always_ff @(posedge clk) begin
    if (rst) begin
      first      <= 1'b1;
      prev_count <= '0;
    end else if (out_acc) begin
      first      <= m_axis_tlast;
      prev_count <= res_count;
    end
  end

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Busy after taking a request
  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("request taken while the previous one is still being tested");

  // The count restarts with each array
  assert property (@(posedge clk) disable iff (rst)
    out_acc && first |-> res_count == count_t'(res_prime))
    else $error("count did not restart at array start");

  // A non-prime leaves the count unchanged within an array
  assert property (@(posedge clk) disable iff (rst)
    out_acc && !first && !res_prime |-> res_count == prev_count)
    else $error("count moved on a non-prime");

endmodule

bind prime_count_stream pcs_check u_pcs_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
